>>> sv/dda_lr_pkg.sv
package dda_lr_pkg;

	localparam int MAX_STEPS_DEF  = 64;
	localparam int COORD_BITS_DEF = 10;

	localparam int ADDR_BITS      = 20;
	localparam int COLOR_BITS     = 24;
	localparam int STRIDE_BITS    = 11;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 11'd1024;
	localparam logic [COLOR_BITS-1:0]  COLOR_RESET  = 24'hB3B3B3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_ROW_STRIDE = 1'b0,
		CFG_LINE_COLOR = 1'b1
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch a new segment
		logic step;   // emit current pixel into output register and advance
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic seg_zero; // segment at the inputs has no pixels
		logic fin;      // current pixel is the final one
	} dp_status_t;

endpackage

>>> sv/dda_lr_ctrl.sv
module dda_lr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  dda_lr_pkg::dp_status_t status,
	output dda_lr_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.step = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load && !status.seg_zero)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.step && status.fin)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/dda_lr_dp.sv
module dda_lr_dp #(
	parameter int MAX_STEPS  = dda_lr_pkg::MAX_STEPS_DEF,
	parameter int COORD_BITS = dda_lr_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  dda_lr_pkg::ctrl_cmd_t                   cmd,
	output dda_lr_pkg::dp_status_t                  status,
	input  logic                                   cfg_we,
	input  logic [dda_lr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dda_lr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic [COORD_BITS-1:0]                  start_x,
	input  logic [COORD_BITS-1:0]                  start_y,
	input  logic [COORD_BITS-1:0]                  end_x,
	input  logic [COORD_BITS-1:0]                  end_y,
	output logic [dda_lr_pkg::ADDR_BITS-1:0]       pixel_address,
	output logic [dda_lr_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                                   last,
	output logic                                   truncated
);

	localparam int STEP_BITS = $clog2(MAX_STEPS + 1);
	localparam int AB        = dda_lr_pkg::ADDR_BITS;

	// configuration
	logic [dda_lr_pkg::STRIDE_BITS-1:0] row_stride_q;
	logic [dda_lr_pkg::COLOR_BITS-1:0]  line_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_stride_q <= dda_lr_pkg::STRIDE_RESET;
			line_color_q <= dda_lr_pkg::COLOR_RESET;
		end else if (cfg_we) begin
			unique case (dda_lr_pkg::cfg_reg_t'(cfg_index))
				dda_lr_pkg::CFG_ROW_STRIDE:
					row_stride_q <= cfg_data[dda_lr_pkg::STRIDE_BITS-1:0];
				dda_lr_pkg::CFG_LINE_COLOR:
					line_color_q <= cfg_data[dda_lr_pkg::COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// segment setup
	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS-1:0]      adx, ady, n_in, amin_in;
	logic                       x_major_in, maj_neg_in, min_neg_in, cut_in;
	logic [STEP_BITS-1:0]       total_in;

	always_comb begin
		dx         = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
		dy         = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
		adx        = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		ady        = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		x_major_in = (adx >= ady);
		n_in       = x_major_in ? adx : ady;
		amin_in    = x_major_in ? ady : adx;
		maj_neg_in = x_major_in ? dx[COORD_BITS] : dy[COORD_BITS];
		min_neg_in = x_major_in ? dy[COORD_BITS] : dx[COORD_BITS];
		cut_in     = (int'(n_in) > MAX_STEPS);
		total_in   = cut_in ? STEP_BITS'(MAX_STEPS) : STEP_BITS'(n_in);
	end

	// stepping state
	logic [COORD_BITS-1:0] pos_major_q, pos_minor_q, rem_q, n_q, amin_q;
	logic                  x_major_q, maj_neg_q, min_neg_q, cut_q;
	logic [STEP_BITS-1:0]  step_q, total_q;

	logic [COORD_BITS:0]   rem_sum;
	logic                  minor_move;
	logic                  fin;
	logic [COORD_BITS-1:0] px, py;
	logic [AB-1:0]         addr;

	always_comb begin
		rem_sum    = {1'b0, rem_q} + {1'b0, amin_q};
		minor_move = (rem_sum >= {1'b0, n_q});
		fin        = ((step_q + STEP_BITS'(1)) == total_q);
		px         = x_major_q ? pos_major_q : pos_minor_q;
		py         = x_major_q ? pos_minor_q : pos_major_q;
		// wraps modulo the address width
		addr       = AB'(py) * AB'(row_stride_q) + AB'(px);
	end

	assign status.seg_zero = (n_in == '0);
	assign status.fin      = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_major_q <= '0;
			pos_minor_q <= '0;
			rem_q       <= '0;
			n_q         <= '0;
			amin_q      <= '0;
			x_major_q   <= 1'b0;
			maj_neg_q   <= 1'b0;
			min_neg_q   <= 1'b0;
			cut_q       <= 1'b0;
			step_q      <= '0;
			total_q     <= '0;
		end else if (cmd.load) begin
			pos_major_q <= x_major_in ? start_x : start_y;
			pos_minor_q <= x_major_in ? start_y : start_x;
			// negative minor delta: bias so floor rounds toward minus infinity
			rem_q       <= min_neg_in ? (n_in - COORD_BITS'(1)) : '0;
			n_q         <= n_in;
			amin_q      <= amin_in;
			x_major_q   <= x_major_in;
			maj_neg_q   <= maj_neg_in;
			min_neg_q   <= min_neg_in;
			cut_q       <= cut_in;
			step_q      <= '0;
			total_q     <= total_in;
		end else if (cmd.step) begin
			pos_major_q <= maj_neg_q ? (pos_major_q - COORD_BITS'(1))
			                         : (pos_major_q + COORD_BITS'(1));
			if (minor_move) begin
				rem_q       <= COORD_BITS'(rem_sum - {1'b0, n_q});
				pos_minor_q <= min_neg_q ? (pos_minor_q - COORD_BITS'(1))
				                         : (pos_minor_q + COORD_BITS'(1));
			end else begin
				rem_q <= rem_sum[COORD_BITS-1:0];
			end
			step_q <= step_q + STEP_BITS'(1);
		end
	end

	// output register, held while the consumer stalls
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			pixel_address <= addr;
			pixel_color   <= line_color_q;
			last          <= fin;
			truncated     <= fin && cut_q;
		end
	end

endmodule

>>> sv/dda_line_rasterizer_unit.sv
// DDA line rasterizer: each input transfer is one segment (start pixel drawn, end pixel
// not), and the block emits one output transfer per pixel carrying y*row_stride + x
// (modulo 2^20), line_color, and last/truncated flags on the final pixel. A segment
// is latched on load and then yields min(n, MAX_STEPS) pixels, n = max(|dx|,|dy|), at
// one pixel per cycle from the single step unit in the datapath while out_stall is low;
// a zero-length segment yields nothing. The next segment is taken as soon as the last
// pixel sits in the output register. Configuration writes are always ready and should
// be made only while the block is idle.
module dda_line_rasterizer_unit #(
	parameter int MAX_STEPS  = dda_lr_pkg::MAX_STEPS_DEF,
	parameter int COORD_BITS = dda_lr_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dda_lr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dda_lr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [COORD_BITS-1:0]                 start_x,
	input  logic [COORD_BITS-1:0]                 start_y,
	input  logic [COORD_BITS-1:0]                 end_x,
	input  logic [COORD_BITS-1:0]                 end_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dda_lr_pkg::ADDR_BITS-1:0]      pixel_address,
	output logic [dda_lr_pkg::COLOR_BITS-1:0]     pixel_color,
	output logic                                  last,
	output logic                                  truncated
);

	dda_lr_pkg::ctrl_cmd_t  cmd;
	dda_lr_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	dda_lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dda_lr_dp #(
		.MAX_STEPS  (MAX_STEPS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last          (last),
		.truncated     (truncated)
	);

endmodule
